// ----- hw/rtl/vvcm_pkg.sv -----
// ----------------------------------------------------------------------------
// vvcm_pkg
// Shared types, codes and small functions of the vertex value color mapper.
// ----------------------------------------------------------------------------
package vvcm_pkg;

  // Input command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_PAINT = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Color modes
  localparam logic [2:0] MODE_HEAT      = 3'd0;
  localparam logic [2:0] MODE_COMPLEX   = 3'd1;
  localparam logic [2:0] MODE_VECTOR    = 3'd2;
  localparam logic [2:0] MODE_NORM_HEAT = 3'd3;
  localparam logic [2:0] MODE_BAND      = 3'd4;
  localparam logic [2:0] MODE_GRAY      = 3'd5;
  localparam logic [2:0] MODE_GRAY_NORM = 3'd6;
  localparam logic [2:0] MODE_RSVD      = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_COLOR_MODE = 3'd0;
  localparam logic [2:0] REG_BAND_COUNT = 3'd1;
  localparam logic [2:0] REG_DARK_BG    = 3'd2;
  localparam logic [2:0] REG_BLUE_CYAN  = 3'd3;
  localparam logic [2:0] REG_GRN_YEL    = 3'd4;
  localparam logic [2:0] REG_RED_MAG    = 3'd5;
  localparam logic [2:0] REG_GRAYS      = 3'd6;

  // Palette color indexes
  localparam logic [2:0] COL_BLUE    = 3'd0;
  localparam logic [2:0] COL_CYAN    = 3'd1;
  localparam logic [2:0] COL_GREEN   = 3'd2;
  localparam logic [2:0] COL_YELLOW  = 3'd3;
  localparam logic [2:0] COL_RED     = 3'd4;
  localparam logic [2:0] COL_MAGENTA = 3'd5;
  localparam logic [2:0] COL_DGRAY   = 3'd6;
  localparam logic [2:0] COL_LGRAY   = 3'd7;

  localparam logic [16:0] ONE_Q = 17'h10000;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CLR, S_SQ, S_SQRT, S_SCAN, S_DSETUP, S_DSTEP, S_VEC,
    S_TINY, S_CSETUP, S_CNORM, S_CORDIC, S_CFIN, S_MIX, S_BLEND, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_SQ, OP_SQRT, OP_SCAN, OP_DSETUP, OP_DSTEP,
    OP_VEC, OP_TINY, OP_CSETUP, OP_CNORM, OP_CORDIC, OP_CFIN, OP_MIX,
    OP_BLEND, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] cnt;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] mode;
    logic       div_trivial;
    logic       norm_done;
    logic       hue_en;
    logic       x_zero;
    logic       y_zero;
  } dp_stat_t;

  // red, green, blue, alpha
  typedef logic [0:3][7:0] rgba_t;

  function automatic logic [15:0] atan_tab(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:  v = 16'd49152;
      4'd1:  v = 16'd29016;
      4'd2:  v = 16'd15331;
      4'd3:  v = 16'd7782;
      4'd4:  v = 16'd3906;
      4'd5:  v = 16'd1955;
      4'd6:  v = 16'd978;
      4'd7:  v = 16'd489;
      4'd8:  v = 16'd244;
      4'd9:  v = 16'd122;
      4'd10: v = 16'd61;
      4'd11: v = 16'd31;
      4'd12: v = 16'd15;
      4'd13: v = 16'd8;
      4'd14: v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  // a*f + b*(1-f), rounded, f in [0,1] with 1.0 = 65536
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [16:0] f);
    logic [24:0] acc;
    acc = 25'(a) * 25'(f) + 25'(b) * 25'(ONE_Q - f) + 25'd32768;
    return acc[23:16];
  endfunction

endpackage

// ----- hw/rtl/vvcm_if.sv -----
// ----------------------------------------------------------------------------
// vvcm channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface vvcm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic [7:0]         band_index;
  modport source (output valid, cmd, comp_x, comp_y, comp_z, band_index, input ready);
  modport sink   (input valid, cmd, comp_x, comp_y, comp_z, band_index, output ready);
endinterface

interface vvcm_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;
  modport source (output valid, red, green, blue, alpha, low_bound, high_bound,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, low_bound, high_bound,
                  output ready);
endinterface

interface vvcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vvcm_datapath.sv -----
// ----------------------------------------------------------------------------
// vvcm_datapath
// Range registers, square-sum and root unit, divider, CORDIC and color mix.
// ----------------------------------------------------------------------------
module vvcm_datapath import vvcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dcmd,
  output dp_stat_t           stat,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [7:0]         in_band,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output rgba_t              out_col,
  output logic signed [31:0] out_low,
  output logic signed [31:0] out_high
);

  logic [1:0]         cmd_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [7:0]         band_r;
  logic [2:0]         mode_r;
  logic [8:0]         bc_r;
  logic               dark_r;
  logic [63:0]        pal_r [0:3];
  logic signed [31:0] lo_r, hi_r;
  logic [63:0]        acc_r;
  logic [31:0]        root_r;
  logic [33:0]        srem_r;
  logic [16:0]        q_r;
  logic [32:0]        rem_r;
  logic [31:0]        den_r;
  logic               hue_en_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [19:0] ang_r, h_r;
  rgba_t              col_r;
  rgba_t              ocol_r;
  logic signed [31:0] olo_r, ohi_r;

  function automatic logic [7:0] chan(input logic [2:0] k, input int ch);
    logic [63:0] w2;
    logic [31:0] w;
    w2 = pal_r[k[2:1]];
    w  = k[0] ? w2[63:32] : w2[31:0];
    return w[31 - 8 * ch -: 8];
  endfunction

  function automatic rgba_t mix(input logic [2:0] a, input logic [2:0] b,
                                input logic [16:0] f);
    rgba_t o;
    for (int ch = 0; ch < 4; ch++) o[ch] = lerp8(chan(a, ch), chan(b, ch), f);
    return o;
  endfunction

  // ---- square sum and root ----
  logic signed [31:0] sq_sel;
  logic [31:0]        sq_abs;
  logic [63:0]        sq;
  logic [35:0]        sr_try, sr_cur;
  logic               sr_ge;
  logic [31:0]        mag32;

  always_comb begin
    unique case (dcmd.cnt[1:0])
      2'd0:    sq_sel = x_r;
      2'd1:    sq_sel = y_r;
      default: sq_sel = (mode_r == MODE_COMPLEX) ? 32'sd0 : z_r;
    endcase
    sq_abs = sq_sel[31] ? (~sq_sel + 32'd1) : sq_sel;
    sq     = 64'(sq_abs) * 64'(sq_abs);
    sr_cur = {srem_r, acc_r[63:62]};
    sr_try = {2'b00, root_r, 2'b01};
    sr_ge  = sr_cur >= sr_try;
    mag32  = root_r[31] ? 32'h7FFF_FFFF : {1'b0, root_r[30:0]};
  end

  // ---- divider setup ----
  logic signed [32:0] v33, lo33, hi33;
  logic [8:0]         nb;
  logic [8:0]         nbm1;
  logic               triv;
  logic [16:0]        triv_q;
  logic [32:0]        num;
  logic [31:0]        den;
  logic [32:0]        r2;
  logic               r2_ge;

  always_comb begin
    lo33 = 33'(lo_r);
    hi33 = 33'(hi_r);
    if (mode_r == MODE_VECTOR) begin
      unique case (dcmd.lane)
        2'd0:    v33 = 33'(x_r);
        2'd1:    v33 = 33'(y_r);
        default: v33 = 33'(z_r);
      endcase
    end else if (mode_r == MODE_HEAT || mode_r == MODE_GRAY) begin
      v33 = 33'(x_r);
    end else begin
      v33 = {1'b0, mag32};
    end
    nb     = (bc_r == 9'd0) ? 9'd1 : bc_r;
    nbm1   = nb - 9'd1;
    triv   = 1'b0;
    triv_q = 17'd0;
    num    = '0;
    den    = '0;
    if (mode_r == MODE_BAND) begin
      if (nbm1 == 9'd0) begin
        triv   = 1'b1;
        triv_q = 17'd32768;
      end else if (9'(band_r) >= nbm1) begin
        triv   = 1'b1;
        triv_q = ONE_Q;
      end else begin
        num = 33'(band_r);
        den = 32'(nbm1);
      end
    end else if (mode_r == MODE_COMPLEX) begin
      if (hi_r <= 32'sd0) begin
        triv = 1'b1;
      end else if (mag32 >= 32'(hi_r)) begin
        triv   = 1'b1;
        triv_q = ONE_Q;
      end else begin
        num = 33'(mag32);
        den = 32'(hi_r);
      end
    end else begin
      if (hi33 <= lo33 || v33 <= lo33) begin
        triv = 1'b1;
      end else if (v33 >= hi33) begin
        triv   = 1'b1;
        triv_q = ONE_Q;
      end else begin
        num = 33'(v33 - lo33);
        den = 32'(hi33 - lo33);
      end
    end
    r2    = {rem_r[31:0], 1'b0};
    r2_ge = r2 >= 33'(den_r);
  end

  // ---- complex phase ----
  logic [47:0]        tiny_p;
  logic signed [35:0] sx, sy;
  logic signed [19:0] tab_v, a_cl, a_mir;
  logic [24:0]        vec_p;

  always_comb begin
    tiny_p = 48'(mag32[30:0]) * 48'(17'd100000);
    sx     = cx_r >>> dcmd.cnt[3:0];
    sy     = cy_r >>> dcmd.cnt[3:0];
    tab_v  = 20'(atan_tab(dcmd.cnt[3:0]));
    if (ang_r < 20'sd0)           a_cl = 20'sd0;
    else if (ang_r > 20'sd98304)  a_cl = 20'sd98304;
    else                          a_cl = ang_r;
    a_mir  = x_r[31] ? (20'sd196608 - a_cl) : a_cl;
    vec_p  = 25'(q_r) * 25'd204;
  end

  // ---- color mixing ----
  logic [18:0] s4;
  logic [16:0] s_f;
  rgba_t       mix_col, blend_col;
  logic [2:0]  org;

  always_comb begin
    s4  = {q_r, 2'b00};
    s_f = 17'(s4);
    if (mode_r == MODE_COMPLEX) begin
      if (h_r < -20'sd131072)     mix_col = mix(COL_BLUE, COL_CYAN, 17'(h_r + 20'sd196608));
      else if (h_r < -20'sd65536) mix_col = mix(COL_MAGENTA, COL_BLUE,
                                                17'(h_r + 20'sd131072));
      else if (h_r < 20'sd0)      mix_col = mix(COL_RED, COL_MAGENTA, 17'(h_r + 20'sd65536));
      else if (h_r < 20'sd65536)  mix_col = mix(COL_YELLOW, COL_RED, 17'(h_r));
      else if (h_r < 20'sd131072) mix_col = mix(COL_GREEN, COL_YELLOW, 17'(h_r - 20'sd65536));
      else                        mix_col = mix(COL_CYAN, COL_GREEN, 17'(h_r - 20'sd131072));
    end else if (mode_r == MODE_GRAY || mode_r == MODE_GRAY_NORM) begin
      mix_col = mix(COL_LGRAY, COL_DGRAY, q_r);
    end else begin
      if (s4 <= 19'h10000)      mix_col = mix(COL_CYAN, COL_BLUE, s_f);
      else if (s4 <= 19'h20000) mix_col = mix(COL_GREEN, COL_CYAN, 17'(s4 - 19'h10000));
      else if (s4 <= 19'h30000) mix_col = mix(COL_YELLOW, COL_GREEN, 17'(s4 - 19'h20000));
      else                      mix_col = mix(COL_RED, COL_YELLOW, 17'(s4 - 19'h30000));
    end
    org = dark_r ? COL_LGRAY : COL_DGRAY;
    for (int ch = 0; ch < 4; ch++) blend_col[ch] = lerp8(col_r[ch], chan(org, ch), q_r);
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HEAT;
      bc_r   <= 9'd1;
      dark_r <= 1'b0;
      for (int i = 0; i < 4; i++) pal_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_MODE: mode_r   <= cfg_data[2:0];
        REG_BAND_COUNT: bc_r     <= cfg_data[8:0];
        REG_DARK_BG:    dark_r   <= cfg_data[0];
        REG_BLUE_CYAN:  pal_r[0] <= cfg_data;
        REG_GRN_YEL:    pal_r[1] <= cfg_data;
        REG_RED_MAG:    pal_r[2] <= cfg_data;
        REG_GRAYS:      pal_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- range ----
  logic signed [31:0] scan_v;
  assign scan_v = (mode_r == MODE_HEAT || mode_r == MODE_GRAY) ? x_r : mag32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= 32'sh7FFF_FFFF;
      hi_r <= 32'sh8000_0000;
    end else if (dcmd.op == OP_CLR) begin
      lo_r <= 32'sh7FFF_FFFF;
      hi_r <= 32'sh8000_0000;
    end else if (dcmd.op == OP_SCAN) begin
      if (scan_v > hi_r) hi_r <= scan_v;
      if (scan_v < lo_r) lo_r <= scan_v;
    end
  end

  // ---- work registers ----
  always_ff @(posedge clk) begin
    unique case (dcmd.op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        x_r    <= in_x;
        y_r    <= in_y;
        z_r    <= in_z;
        band_r <= in_band;
        col_r  <= '0;
      end
      OP_SQ: begin
        acc_r <= (dcmd.cnt == 5'd0) ? sq : acc_r + sq;
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT: begin
        acc_r  <= {acc_r[61:0], 2'b00};
        root_r <= {root_r[30:0], sr_ge};
        srem_r <= sr_ge ? 34'(sr_cur - sr_try) : 34'(sr_cur);
      end
      OP_DSETUP: begin
        q_r   <= triv ? triv_q : 17'd0;
        rem_r <= num;
        den_r <= den;
      end
      OP_DSTEP: begin
        rem_r <= r2_ge ? (r2 - 33'(den_r)) : r2;
        q_r   <= {q_r[15:0], r2_ge};
      end
      OP_VEC: begin
        col_r[dcmd.lane] <= 8'd26 + vec_p[23:16];
        col_r[3]         <= 8'd255;
      end
      OP_TINY: hue_en_r <= (hi_r > 32'sd0) && (tiny_p >= 48'(hi_r));
      OP_CSETUP: begin
        cx_r  <= x_r[31] ? -36'(x_r) : 36'(x_r);
        cy_r  <= y_r[31] ? -36'(y_r) : 36'(y_r);
        ang_r <= (y_r != 32'sd0 && x_r == 32'sd0) ? 20'sd98304 : 20'sd0;
        h_r   <= 20'sd0;
      end
      OP_CNORM: begin
        if (!stat.norm_done) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      OP_CORDIC: begin
        if (cy_r > 36'sd0) begin
          cx_r  <= cx_r + sy;
          cy_r  <= cy_r - sx;
          ang_r <= ang_r + tab_v;
        end else begin
          cx_r  <= cx_r - sy;
          cy_r  <= cy_r + sx;
          ang_r <= ang_r - tab_v;
        end
      end
      OP_CFIN:  h_r   <= (y_r > 32'sd0) ? a_mir : -a_mir;
      OP_MIX:   col_r <= mix_col;
      OP_BLEND: col_r <= blend_col;
      OP_OUT: begin
        ocol_r <= col_r;
        olo_r  <= lo_r;
        ohi_r  <= hi_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.cmd         = cmd_r;
    stat.mode        = mode_r;
    stat.div_trivial = triv;
    stat.norm_done   = (cx_r >= 36'sh4000_0000) || (cy_r >= 36'sh4000_0000);
    stat.hue_en      = hue_en_r;
    stat.x_zero      = x_r == 32'sd0;
    stat.y_zero      = y_r == 32'sd0;
  end

  assign out_col  = ocol_r;
  assign out_low  = olo_r;
  assign out_high = ohi_r;

endmodule

// ----- hw/rtl/vvcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// vvcm_ctrl
// Sequencer: steps the datapath through each command and owns the handshakes.
// ----------------------------------------------------------------------------
module vvcm_ctrl import vvcm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  state_t     state_r, state_nxt, after_div;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (stat.mode == MODE_VECTOR)       after_div = S_VEC;
    else if (stat.mode == MODE_COMPLEX) after_div = S_BLEND;
    else                                after_div = S_MIX;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        priority if (stat.cmd == CMD_CLEAR) begin
          state_nxt = S_CLR;
        end else if (stat.cmd == CMD_SCAN) begin
          if (stat.mode == MODE_HEAT || stat.mode == MODE_GRAY) state_nxt = S_SCAN;
          else if (stat.mode == MODE_BAND || stat.mode == MODE_RSVD) state_nxt = S_OUT;
          else                                                  state_nxt = S_SQ;
        end else if (stat.cmd == CMD_PAINT) begin
          if (stat.mode == MODE_COMPLEX || stat.mode == MODE_NORM_HEAT ||
              stat.mode == MODE_GRAY_NORM)                      state_nxt = S_SQ;
          else if (stat.mode == MODE_RSVD)                      state_nxt = S_OUT;
          else                                                  state_nxt = S_DSETUP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CLR:  state_nxt = S_OUT;
      S_SCAN: state_nxt = S_OUT;
      S_SQ:   if (cnt_r == 5'd2) state_nxt = S_SQRT;
      S_SQRT: begin
        if (cnt_r == 5'd31) begin
          if (stat.cmd == CMD_SCAN)           state_nxt = S_SCAN;
          else if (stat.mode == MODE_COMPLEX) state_nxt = S_TINY;
          else                                state_nxt = S_DSETUP;
        end
      end
      S_DSETUP: state_nxt = stat.div_trivial ? after_div : S_DSTEP;
      S_DSTEP:  if (cnt_r == 5'd15) state_nxt = after_div;
      S_VEC:    state_nxt = (lane_r == 2'd2) ? S_OUT : S_DSETUP;
      S_TINY:   state_nxt = S_CSETUP;
      S_CSETUP: begin
        if (!stat.hue_en)                    state_nxt = S_MIX;
        else if (stat.x_zero || stat.y_zero) state_nxt = S_CFIN;
        else                                 state_nxt = S_CNORM;
      end
      S_CNORM:  if (stat.norm_done) state_nxt = S_CORDIC;
      S_CORDIC: if (cnt_r == 5'd15) state_nxt = S_CFIN;
      S_CFIN:   state_nxt = S_MIX;
      S_MIX:    state_nxt = (stat.mode == MODE_COMPLEX) ? S_DSETUP : S_OUT;
      S_BLEND:  state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dcmd.cnt  = cnt_r;
    dcmd.lane = lane_r;
    in_ready  = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE:   dcmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_CLR:    dcmd.op = OP_CLR;
      S_SQ:     dcmd.op = OP_SQ;
      S_SQRT:   dcmd.op = OP_SQRT;
      S_SCAN:   dcmd.op = OP_SCAN;
      S_DSETUP: dcmd.op = OP_DSETUP;
      S_DSTEP:  dcmd.op = OP_DSTEP;
      S_VEC:    dcmd.op = OP_VEC;
      S_TINY:   dcmd.op = OP_TINY;
      S_CSETUP: dcmd.op = OP_CSETUP;
      S_CNORM:  dcmd.op = OP_CNORM;
      S_CORDIC: dcmd.op = OP_CORDIC;
      S_CFIN:   dcmd.op = OP_CFIN;
      S_MIX:    dcmd.op = OP_MIX;
      S_BLEND:  dcmd.op = OP_BLEND;
      S_OUT:    dcmd.op = out_free ? OP_OUT : OP_NONE;
      default:  dcmd.op = OP_NONE;
    endcase
    cnt_nxt  = (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
    lane_nxt = lane_r;
    if (state_r == S_DISP)     lane_nxt = 2'd0;
    else if (state_r == S_VEC) lane_nxt = lane_r + 2'd1;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (state_r == S_OUT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while an item is in flight");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP) |-> (cnt_r < 5'd16))
    else $error("divider ran past its quotient width");

endmodule

// ----- hw/rtl/vertex_value_color_mapper.sv -----
// ----------------------------------------------------------------------------
// vertex_value_color_mapper
// Tracks a value range and turns vertex quantities into RGBA8 colors.
// ----------------------------------------------------------------------------
// in_ch takes one item (clear, scan or paint) per beat; out_ch returns one
// result per item: the color (zero unless paint) and the range after it.
// cfg_ch writes the registers and is always ready; the user is to use it only
// while idle, as the block does not enforce this. One item is in work at a time.
// Its work runs through the 32-step square root, the 16-step divider, the
// pre-CORDIC normalize shift and the 16-step CORDIC, as command and mode need.
// The result sits in an output register, so the next item is taken while
// a result waits; a stalled receiver holds the block only at its next
// result. Reset clears the range to empty (low most positive, high most
// negative) and the registers to their defaults.
// ----------------------------------------------------------------------------
module vertex_value_color_mapper import vvcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vvcm_in_if.sink    in_ch,
  vvcm_out_if.source out_ch,
  vvcm_cfg_if.sink   cfg_ch
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;
  rgba_t    col;

  assign cfg_ch.ready = 1'b1;

  vvcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .dcmd      (dcmd)
  );

  vvcm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dcmd      (dcmd),
    .stat      (stat),
    .in_cmd    (in_ch.cmd),
    .in_x      (in_ch.comp_x),
    .in_y      (in_ch.comp_y),
    .in_z      (in_ch.comp_z),
    .in_band   (in_ch.band_index),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_col   (col),
    .out_low   (out_ch.low_bound),
    .out_high  (out_ch.high_bound)
  );

  assign out_ch.red   = col[0];
  assign out_ch.green = col[1];
  assign out_ch.blue  = col[2];
  assign out_ch.alpha = col[3];

endmodule

// ----- tb/vvcm_checker.sv -----
// ----------------------------------------------------------------------------
// vvcm_checker
// Watches the item, result and register channels of the color mapper,
// predicts the color and range of every accepted item and compares each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vvcm_checker import vvcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vvcm_in_if   in_ch,
  vvcm_out_if  out_ch,
  vvcm_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
  } color_beat_t;

  localparam longint RANGE_LOW_RST  = 64'sh7FFF_FFFF;
  localparam longint RANGE_HIGH_RST = -64'sh8000_0000;

  color_beat_t       color_q[$];
  logic [2:0]        mode_r;
  logic [8:0]        bands_r;
  logic              dark_r;
  longint unsigned   pal_r[4];
  longint            lo_r;
  longint            hi_r;

  assign pending = color_q.size();

  function automatic longint unsigned vec_mag(longint x, longint y, longint z);
    longint unsigned ax, ay, az, n, res, bit_w;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    n = ax * ax + ay * ay + az * az;
    res = 0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : res;
  endfunction

  function automatic int unsigned norm_frac(longint v, longint lo, longint hi);
    if (hi <= lo || v <= lo) return 0;
    if (v >= hi) return 65536;
    return int'(((v - lo) << 16) / (hi - lo));
  endfunction

  function automatic int unsigned pal_chan(int k, int ch);
    longint unsigned w;
    w = pal_r[(k >> 1) & 3] >> ((k & 1) * 32);
    return int'((w >> (24 - 8 * ch)) & 64'hFF);
  endfunction

  function automatic int unsigned blend8(int unsigned a, int unsigned b, int unsigned f);
    return (a * f + b * (65536 - f) + 32768) >> 16;
  endfunction

  function automatic void pal_mix(output int unsigned o[4], input int ka, input int kb,
                                  input int unsigned f);
    for (int ch = 0; ch < 4; ch++) o[ch] = blend8(pal_chan(ka, ch), pal_chan(kb, ch), f);
  endfunction

  function automatic void heat_ramp(output int unsigned o[4], input int unsigned t);
    int unsigned s;
    s = 4 * t;
    if (s <= 65536) pal_mix(o, COL_CYAN, COL_BLUE, s);
    else if (s <= 131072) pal_mix(o, COL_GREEN, COL_CYAN, s - 65536);
    else if (s <= 196608) pal_mix(o, COL_YELLOW, COL_GREEN, s - 131072);
    else pal_mix(o, COL_RED, COL_YELLOW, s - 196608);
  endfunction

  function automatic longint phase_of(longint x, longint y);
    longint ax, ay, a, cx, cy, nx;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (ay == 0) a = 0;
    else if (ax == 0) a = 98304;
    else begin
      while (ax < (64'sd1 << 30) && ay < (64'sd1 << 30)) begin
        ax <<= 1;
        ay <<= 1;
      end
      cx = ax;
      cy = ay;
      a = 0;
      for (int i = 0; i < 16; i++) begin
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          a += atan_tab(4'(i));
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          a -= atan_tab(4'(i));
        end
        cx = nx;
      end
      if (a < 0) a = 0;
      if (a > 98304) a = 98304;
    end
    if (x < 0) a = 196608 - a;
    return y > 0 ? a : -a;
  endfunction

  function automatic void phase_color(output int unsigned o[4], input longint x,
                                      input longint y);
    longint unsigned m, q;
    longint h;
    int unsigned hue[4], mw;
    int org;
    m = vec_mag(x, y, 0);
    h = 0;
    mw = 0;
    org = dark_r ? COL_LGRAY : COL_DGRAY;
    if (hi_r > 0 && longint'(m) * 100000 >= hi_r) h = phase_of(x, y);
    if (h < -131072) pal_mix(hue, COL_BLUE, COL_CYAN, int'(h + 196608));
    else if (h < -65536) pal_mix(hue, COL_MAGENTA, COL_BLUE, int'(h + 131072));
    else if (h < 0) pal_mix(hue, COL_RED, COL_MAGENTA, int'(h + 65536));
    else if (h < 65536) pal_mix(hue, COL_YELLOW, COL_RED, int'(h));
    else if (h < 131072) pal_mix(hue, COL_GREEN, COL_YELLOW, int'(h - 65536));
    else pal_mix(hue, COL_CYAN, COL_GREEN, int'(h - 131072));
    if (hi_r > 0) begin
      q = (m << 16) / longint'(hi_r);
      mw = q > 65536 ? 65536 : int'(q);
    end
    for (int ch = 0; ch < 4; ch++) o[ch] = blend8(hue[ch], pal_chan(org, ch), mw);
  endfunction

  // Advance the tracked range and return the color of one item.
  function automatic color_beat_t map_vertex(logic [1:0] cmd, longint x, longint y,
                                             longint z, logic [7:0] band);
    int unsigned col[4], nb, q;
    longint v;
    color_beat_t e;
    col = '{0, 0, 0, 0};
    if (cmd == CMD_CLEAR) begin
      lo_r = RANGE_LOW_RST;
      hi_r = RANGE_HIGH_RST;
    end else if (cmd == CMD_SCAN) begin
      if (mode_r <= MODE_GRAY_NORM && mode_r != MODE_BAND) begin
        if (mode_r == MODE_HEAT || mode_r == MODE_GRAY) v = x;
        else if (mode_r == MODE_COMPLEX) v = longint'(vec_mag(x, y, 0));
        else v = longint'(vec_mag(x, y, z));
        if (v > hi_r) hi_r = v;
        if (v < lo_r) lo_r = v;
      end
    end else if (cmd == CMD_PAINT) begin
      case (mode_r)
        MODE_HEAT: heat_ramp(col, norm_frac(x, lo_r, hi_r));
        MODE_COMPLEX: phase_color(col, x, y);
        MODE_VECTOR: begin
          col[0] = 26 + ((204 * norm_frac(x, lo_r, hi_r)) >> 16);
          col[1] = 26 + ((204 * norm_frac(y, lo_r, hi_r)) >> 16);
          col[2] = 26 + ((204 * norm_frac(z, lo_r, hi_r)) >> 16);
          col[3] = 255;
        end
        MODE_NORM_HEAT: heat_ramp(col, norm_frac(longint'(vec_mag(x, y, z)), lo_r, hi_r));
        MODE_BAND: begin
          nb = bands_r == 0 ? 1 : bands_r;
          if (nb == 1) q = 32768;
          else begin
            q = (int'(band) << 16) / (nb - 1);
            if (q > 65536) q = 65536;
          end
          heat_ramp(col, q);
        end
        MODE_GRAY: pal_mix(col, COL_LGRAY, COL_DGRAY, norm_frac(x, lo_r, hi_r));
        MODE_GRAY_NORM:
          pal_mix(col, COL_LGRAY, COL_DGRAY,
                  norm_frac(longint'(vec_mag(x, y, z)), lo_r, hi_r));
        default: ;
      endcase
    end
    e.red = col[0][7:0];
    e.green = col[1][7:0];
    e.blue = col[2][7:0];
    e.alpha = col[3][7:0];
    e.low_bound = lo_r[31:0];
    e.high_bound = hi_r[31:0];
    return e;
  endfunction

  always @(posedge clk) begin
    color_beat_t e;
    if (!rst_n) begin
      mode_r <= MODE_HEAT;
      bands_r <= 9'd1;
      dark_r <= 1'b0;
      pal_r <= '{0, 0, 0, 0};
      lo_r = RANGE_LOW_RST;
      hi_r = RANGE_HIGH_RST;
      color_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_COLOR_MODE: mode_r <= cfg_ch.data[2:0];
          REG_BAND_COUNT: bands_r <= cfg_ch.data[8:0];
          REG_DARK_BG:    dark_r <= cfg_ch.data[0];
          REG_BLUE_CYAN:  pal_r[0] <= cfg_ch.data;
          REG_GRN_YEL:    pal_r[1] <= cfg_ch.data;
          REG_RED_MAG:    pal_r[2] <= cfg_ch.data;
          REG_GRAYS:      pal_r[3] <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (color_q.size() == 0) begin
          $display("%0t: result beat with no prediction: rgba %h%h%h%h lo %h hi %h",
                   $time, out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                   out_ch.low_bound, out_ch.high_bound);
          fail_count <= fail_count + 1;
        end else begin
          e = color_q.pop_front();
          if (e.red !== out_ch.red || e.green !== out_ch.green ||
              e.blue !== out_ch.blue || e.alpha !== out_ch.alpha ||
              e.low_bound !== out_ch.low_bound || e.high_bound !== out_ch.high_bound) begin
            $display("%0t: expected rgba %h %h %h %h lo %h hi %h, got %h %h %h %h lo %h hi %h",
                     $time, e.red, e.green, e.blue, e.alpha, e.low_bound, e.high_bound,
                     out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                     out_ch.low_bound, out_ch.high_bound);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        color_q.push_back(map_vertex(in_ch.cmd, longint'(in_ch.comp_x),
                                     longint'(in_ch.comp_y), longint'(in_ch.comp_z),
                                     in_ch.band_index));
    end
  end

endmodule

// ----- tb/tb_vertex_value_color_mapper.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_value_color_mapper
// Drives directed and random clear, scan, paint and unused-command items
// through every color mode with writes to every register, with random stalls on
// both channels; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vertex_value_color_mapper;
  import vvcm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ROUNDS      = 28;
  localparam int ROUND_ITEMS = 50;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  int   tx_pct;
  int   rx_pct;

  vvcm_in_if  in_ch();
  vvcm_out_if out_ch();
  vvcm_cfg_if cfg_ch();

  vertex_value_color_mapper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vvcm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(0, 1 << 18));
      5: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
    endcase
  endfunction

  // Hold valid across back-to-back beats; drop it only for a sender gap.
  task automatic send_vertex(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [7:0] band);
    int gap;
    gap = 0;
    tx_pct = sent < 470 ? 6 : (sent < 940 ? 65 : 0);
    rx_pct = sent < 470 ? 65 : (sent < 940 ? 6 : 0);
    while ($urandom_range(0, 99) < tx_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    in_ch.band_index <= band;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_palette(int style);
    for (int r = 3; r <= 6; r++) begin
      case (style)
        0: write_reg(3'(r), '1);
        1: write_reg(3'(r), '0);
        default: write_reg(3'(r), {$urandom, $urandom});
      endcase
    end
  endtask

  task automatic random_vertex();
    int pick;
    logic [1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = CMD_SCAN;
    else if (pick < 85) cmd = CMD_PAINT;
    else if (pick < 93) cmd = CMD_CLEAR;
    else cmd = CMD_RSVD;
    send_vertex(cmd, rand_q(), rand_q(), rand_q(), 8'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    sent = 0;
    tx_pct = 6;
    rx_pct = 65;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    in_ch.band_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_COLOR_MODE;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty range, extremes, unused command, tiny and axis phases,
    // band counts of zero and two, unused mode.
    send_vertex(CMD_PAINT, 32'h1234_5678, '0, '0, '0);
    drain_results();
    write_palette(2);
    send_vertex(CMD_SCAN, 32'h7FFF_FFFF, '0, '0, '0);
    send_vertex(CMD_PAINT, 32'h7FFF_FFFF, '0, '0, '0);
    send_vertex(CMD_SCAN, 32'h8000_0000, '0, '0, '0);
    send_vertex(CMD_PAINT, 32'h0000_0000, '0, '0, '0);
    send_vertex(CMD_PAINT, 32'h8000_0000, '0, '0, '0);
    send_vertex(CMD_RSVD, '1, '1, '1, '1);
    send_vertex(CMD_CLEAR, '0, '0, '0, '0);
    drain_results();
    write_reg(REG_COLOR_MODE, 64'(MODE_COMPLEX));
    write_reg(REG_DARK_BG, 64'd1);
    send_vertex(CMD_PAINT, 32'h0001_0000, 32'h0001_0000, '0, '0);
    send_vertex(CMD_SCAN, 32'h0004_0000, 32'h0003_0000, '0, '0);
    send_vertex(CMD_PAINT, 32'h0000_0000, 32'hFFFF_0000, '0, '0);
    send_vertex(CMD_PAINT, 32'hFFFF_0000, 32'h0000_0000, '0, '0);
    send_vertex(CMD_PAINT, 32'h0000_0001, 32'h0000_0000, '0, '0);
    send_vertex(CMD_PAINT, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_vertex(CMD_PAINT, 32'h7FFF_FFFF, 32'h8000_0001, '0, '0);
    drain_results();
    write_reg(REG_COLOR_MODE, 64'(MODE_BAND));
    write_reg(REG_BAND_COUNT, 64'd0);
    send_vertex(CMD_SCAN, 32'h0001_0000, '0, '0, 8'd3);
    send_vertex(CMD_PAINT, '0, '0, '0, 8'd255);
    drain_results();
    write_reg(REG_BAND_COUNT, 64'd2);
    send_vertex(CMD_PAINT, '0, '0, '0, 8'd0);
    send_vertex(CMD_PAINT, '0, '0, '0, 8'd255);
    drain_results();
    write_reg(REG_COLOR_MODE, 64'(MODE_RSVD));
    send_vertex(CMD_SCAN, 32'h0002_0000, '0, '0, '0);
    send_vertex(CMD_PAINT, 32'h0002_0000, '0, '0, '0);
    drain_results();

    for (int r = 0; r < ROUNDS; r++) begin
      write_reg(REG_COLOR_MODE, 64'(r % 8));
      case (r % 4)
        0: write_reg(REG_BAND_COUNT, 64'd1);
        1: write_reg(REG_BAND_COUNT, 64'd256);
        2: write_reg(REG_BAND_COUNT, 64'd511);
        default: write_reg(REG_BAND_COUNT, 64'($urandom_range(0, 511)));
      endcase
      write_reg(REG_DARK_BG, 64'($urandom_range(0, 1)));
      write_palette(r < 2 ? r : 2);
      send_vertex(CMD_CLEAR, '0, '0, '0, '0);
      for (int i = 0; i < ROUND_ITEMS; i++) begin
        // Seed the range with scans first so most paints land inside it.
        if (i < 4) send_vertex(CMD_SCAN, rand_q(), rand_q(), rand_q(), 8'($urandom));
        else random_vertex();
      end
      drain_results();
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
